>>> src/pose_exact_arc_integrator_defines.svh
// Assertion macros shared by the pose integrator RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef POSE_EXACT_ARC_INTEGRATOR_DEFINES_SVH
`define POSE_EXACT_ARC_INTEGRATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define PEAI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PEAI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PEAI_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PEAI_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> src/peai_pkg.sv
// Package for the pose integrator: types, constants, CORDIC angle table.
// Depends on nothing.
`timescale 1ns / 1ps
package peai_pkg;
  localparam int CordicIters = 30;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic [31:0] InvTwoPi = 32'd683565276;

  typedef enum logic [3:0] {
    ST_IDLE, ST_HCORDIC, ST_ROT_M, ST_ROT_SUM, ST_ANGLE, ST_ACORDIC,
    ST_ARC_M, ST_ARC_SUM, ST_DIV, ST_LINE, ST_UPDATE, ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic [31:0] angle;
  } cordic_req_t;

  typedef struct packed {
    logic done;
    logic busy;
  } unit_stat_t;

  function automatic logic [31:0] atan_q(input logic [4:0] i);
    logic [31:0] r;
    begin
      case (i)
        5'd0: r = 32'd536870912; 5'd1: r = 32'd316933406; 5'd2: r = 32'd167458907;
        5'd3: r = 32'd85004756; 5'd4: r = 32'd42667331; 5'd5: r = 32'd21354465;
        5'd6: r = 32'd10679838; 5'd7: r = 32'd5340245; 5'd8: r = 32'd2670163;
        5'd9: r = 32'd1335087; 5'd10: r = 32'd667544; 5'd11: r = 32'd333772;
        5'd12: r = 32'd166886; 5'd13: r = 32'd83443; 5'd14: r = 32'd41722;
        5'd15: r = 32'd20861; 5'd16: r = 32'd10430; 5'd17: r = 32'd5215;
        5'd18: r = 32'd2608; 5'd19: r = 32'd1304; 5'd20: r = 32'd652;
        5'd21: r = 32'd326; 5'd22: r = 32'd163; 5'd23: r = 32'd81;
        5'd24: r = 32'd41; 5'd25: r = 32'd20; 5'd26: r = 32'd10;
        5'd27: r = 32'd5; 5'd28: r = 32'd3; 5'd29: r = 32'd1;
        default: r = 32'd0;
      endcase
      return r;
    end
  endfunction
endpackage

>>> src/peai_cordic.sv
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, Q2.30 sin/cos.
// Depends on peai_pkg.
`timescale 1ns / 1ps
`include "pose_exact_arc_integrator_defines.svh"
module peai_cordic (
  input  logic                 clk,
  input  logic                 rst_n,
  input  peai_pkg::cordic_req_t req,
  output peai_pkg::unit_stat_t stat,
  output logic signed [33:0]   cos_q,
  output logic signed [33:0]   sin_q
);
  import peai_pkg::*;

  logic signed [33:0] x_r, y_r, x_nxt, y_nxt;
  logic signed [33:0] z_r, z_nxt;
  logic [4:0] it_r, it_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt, neg_r, neg_nxt;
  logic [31:0] fa;
  logic qneg;

  // fold the angle into the right half plane
  assign qneg = (req.angle[31:30] == 2'b01) || (req.angle[31:30] == 2'b10);
  assign fa = qneg ? req.angle + 32'h8000_0000 : req.angle;

  // micro-rotation
  always_comb begin
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r; it_nxt = it_r;
    busy_nxt = busy_r; done_nxt = 1'b0; neg_nxt = neg_r;
    if (req.start) begin
      x_nxt = CordicGain; y_nxt = '0;
      z_nxt = {{2{fa[31]}}, fa};
      it_nxt = '0; busy_nxt = 1'b1; neg_nxt = qneg;
    end else if (busy_r) begin
      if (!z_r[33]) begin
        x_nxt = x_r - (y_r >>> it_r); y_nxt = y_r + (x_r >>> it_r);
        z_nxt = z_r - $signed({2'b00, atan_q(it_r)});
      end else begin
        x_nxt = x_r + (y_r >>> it_r); y_nxt = y_r - (x_r >>> it_r);
        z_nxt = z_r + $signed({2'b00, atan_q(it_r)});
      end
      it_nxt = it_r + 5'd1;
      if (it_r == 5'(CordicIters - 1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt; it_r <= it_nxt; neg_r <= neg_nxt;
  end

  assign stat.done = done_r;
  assign stat.busy = busy_r;
  assign cos_q = neg_r ? -x_r : x_r;
  assign sin_q = neg_r ? -y_r : y_r;

  `PEAI_ASSERT_NXT(a_done_ends_busy, clk, rst_n, busy_r && it_r == 5'(CordicIters - 1), done_r && !busy_r)
  `PEAI_ASSERT_IMP(a_done_not_busy, clk, rst_n, done_r, !busy_r)
  `PEAI_ASSERT_NXT(a_start_busy, clk, rst_n, req.start, busy_r)
endmodule

>>> src/peai_divider.sv
// Restoring divider: signed 64-bit dividend by signed 40-bit divisor, one
// quotient bit per cycle, quotient truncated toward zero. Depends on peai_pkg.
`timescale 1ns / 1ps
module peai_divider (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [63:0]   num,
  input  logic signed [39:0]   den,
  output peai_pkg::unit_stat_t stat,
  output logic signed [63:0]   quo
);
  import peai_pkg::*;

  logic [63:0] q_r, q_nxt;
  logic [39:0] rem_r, rem_nxt, d_r, d_nxt;
  logic [40:0] trial;
  logic [5:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt, sgn_r, sgn_nxt;

  assign trial = {rem_r, q_r[63]} - {1'b0, d_r};

  // shift-subtract step
  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; d_nxt = d_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0; sgn_nxt = sgn_r;
    if (start) begin
      q_nxt = num[63] ? 64'(-num) : num;
      d_nxt = den[39] ? 40'(-den) : den;
      rem_nxt = '0; cnt_nxt = '0; busy_nxt = 1'b1;
      sgn_nxt = num[63] ^ den[39];
    end else if (busy_r) begin
      if (!trial[40]) begin
        rem_nxt = trial[39:0]; q_nxt = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[38:0], q_r[63]}; q_nxt = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt; d_r <= d_nxt; cnt_r <= cnt_nxt; sgn_r <= sgn_nxt;
  end

  assign stat.done = done_r;
  assign stat.busy = busy_r;
  assign quo = sgn_r ? -$signed(q_r) : $signed(q_r);
endmodule

>>> src/peai_mul.sv
// Registered 34x34 signed multiplier, shared by all product steps.
// Depends on peai_pkg.
`timescale 1ns / 1ps
module peai_mul (
  input  logic               clk,
  input  logic signed [33:0] a,
  input  logic signed [33:0] b,
  output logic signed [67:0] p
);
  import peai_pkg::*;
  logic signed [67:0] p_r;
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end
  assign p = p_r;
endmodule

>>> src/pose_exact_arc_integrator.sv
// Top level of the dead-reckoning pose integrator: sequencer, pose state.
// Depends on peai_pkg, peai_cordic, peai_divider, peai_mul.
`timescale 1ns / 1ps
`include "pose_exact_arc_integrator_defines.svh"
// Usage:
//   Input words on in_* carry one command: integrate a twist over a time
//   step (in_tuser = 0) or load a pose (in_tuser = 1). Each accepted word
//   produces exactly one output word on out_* with the updated pose and a
//   saturation flag.
//   One word is worked on at a time; in_tready is low from acceptance until
//   the result is taken. A load goes straight to the pose update, which
//   raises out_tvalid. An integrate in world frame with nonzero turn and
//   step runs the angle product, the CORDIC, four multiplies, two divides
//   and the pose update before it raises out_tvalid. A body-frame
//   integrate adds the heading CORDIC and the frame rotation before these.
//   A straight-line step skips the arc CORDIC and the divides and uses two
//   multiplies instead.
//   Reset clears the pose to zero and heading to zero, drops out_tvalid.
//   While out_tready is low the result holds and no new word is taken.
module pose_exact_arc_integrator (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // in_tdata: vel_x[23:0], vel_y[47:24], turn_rate[71:48], body_frame[72],
  //   step_time[88:73], load_x[120:89], load_y[152:121], load_heading[168:153]
  input  logic [175:0] in_tdata,
  input  logic         in_tuser, // command
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_tdata: pose_x[31:0], pose_y[63:32], pose_heading[79:64], saturated[80]
  output logic [87:0]  out_tdata
);
  import peai_pkg::*;

  state_t st_r, st_nxt;
  logic cmd_r;
  logic signed [23:0] vx_in_r, vy_in_r, w_r;
  logic [15:0] dt_r;
  logic signed [31:0] lx_r, ly_r;
  logic [15:0] lh_r;
  logic signed [31:0] px_r, py_r;
  logic [15:0] hd_r;
  logic signed [33:0] vx_r, vy_r;     // velocity after frame rotation
  logic signed [67:0] acc_r;
  logic signed [63:0] nx_r, ny_r;
  logic signed [63:0] dx_r, dy_r;
  logic [31:0] a32_r;
  logic [2:0] ph_r;
  logic sat_r;
  logic ovalid_r;
  logic div2_r;

  // shared units
  cordic_req_t creq;
  unit_stat_t cst, dst;
  logic signed [33:0] cc, cs;
  logic signed [33:0] ma, mb;
  logic signed [67:0] mp;
  logic dstart;
  logic signed [63:0] dnum, dquo;
  logic signed [39:0] dden;

  peai_cordic u_cordic (.clk, .rst_n, .req(creq), .stat(cst), .cos_q(cc), .sin_q(cs));
  peai_mul u_mul (.clk, .a(ma), .b(mb), .p(mp));
  peai_divider u_div (.clk, .rst_n, .start(dstart), .num(dnum), .den(dden),
    .stat(dst), .quo(dquo));

  logic accept;
  assign accept = in_tvalid && in_tready;
  assign in_tready = (st_r == ST_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata = {7'd0, sat_r, hd_r, py_r, px_r};

  logic straight;
  assign straight = (w_r == '0) || (dt_r == '0);
  logic signed [33:0] c1;
  assign c1 = cc - 34'sd1073741824;

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:    if (accept) st_nxt = in_tuser ? ST_UPDATE :
                    (in_tdata[72] ? ST_HCORDIC : ST_ANGLE);
      ST_HCORDIC: if (cst.done) st_nxt = ST_ROT_M;
      ST_ROT_M:   if (ph_r == 3'd5) st_nxt = ST_ANGLE;
      ST_ROT_SUM: st_nxt = ST_ANGLE;
      ST_ANGLE:   if (ph_r == 3'd5) st_nxt = straight ? ST_LINE : ST_ACORDIC;
      ST_ACORDIC: if (cst.done) st_nxt = ST_ARC_M;
      ST_ARC_M:   if (ph_r == 3'd5) st_nxt = ST_DIV;
      ST_ARC_SUM: st_nxt = ST_DIV;
      ST_DIV:     if (dst.done && div2_r) st_nxt = ST_UPDATE;
      ST_LINE:    if (ph_r == 3'd3) st_nxt = ST_UPDATE;
      ST_UPDATE:  st_nxt = ST_OUT;
      ST_OUT:     if (out_tready) st_nxt = ST_IDLE;
      default:    st_nxt = ST_IDLE;
    endcase
  end

  // unit controls
  always_comb begin
    creq.start = 1'b0;
    creq.angle = {hd_r, 16'd0};
    ma = '0; mb = '0;
    dstart = 1'b0;
    dnum = nx_r; dden = 40'(w_r) <<< 14;
    unique case (st_r)
      ST_IDLE: creq.start = accept && !in_tuser && in_tdata[72];
      ST_ROT_M: begin
        unique case (ph_r)
          3'd0: begin ma = cc; mb = 34'(vx_in_r); end
          3'd1: begin ma = cs; mb = 34'(vy_in_r); end
          3'd2: begin ma = cs; mb = 34'(vx_in_r); end
          default: begin ma = cc; mb = 34'(vy_in_r); end
        endcase
      end
      ST_ANGLE: begin
        // w*dt, then low and high words of the product times 1/(2pi)
        unique case (ph_r)
          3'd0: begin ma = 34'(w_r); mb = $signed({18'd0, dt_r}); end
          3'd2: begin ma = $signed({2'b00, acc_r[31:0]}); mb = $signed({2'b00, InvTwoPi}); end
          3'd3: begin ma = 34'($signed(acc_r[39:32])); mb = $signed({2'b00, InvTwoPi}); end
          default: ;
        endcase
        creq.angle = a32_r;
        creq.start = (ph_r == 3'd5) && !straight;
      end
      ST_ACORDIC: creq.angle = a32_r;
      ST_ARC_M: begin
        unique case (ph_r)
          3'd0: begin ma = cs; mb = vx_r; end
          3'd1: begin ma = c1; mb = vy_r; end
          3'd2: begin ma = cs; mb = vy_r; end
          default: begin ma = c1; mb = vx_r; end
        endcase
      end
      ST_DIV: begin
        // dx first; dy starts in the cycle dx returns
        dnum = dst.done ? ny_r : nx_r;
        dstart = (ph_r == 3'd0 && !div2_r && !dst.busy && !dst.done) ||
                 (dst.done && !div2_r);
      end
      ST_LINE: begin
        unique case (ph_r)
          3'd0: begin ma = vx_r; mb = $signed({18'd0, dt_r}); end
          default: begin ma = vy_r; mb = $signed({18'd0, dt_r}); end
        endcase
      end
      default: ;
    endcase
  end

  // saturating add
  function automatic logic [32:0] sat_add(input logic signed [31:0] p,
                                          input logic signed [63:0] d);
    logic signed [64:0] r;
    begin
      r = 65'(p) + 65'(d);
      if (r > 65'sd2147483647) return {1'b1, 32'h7FFF_FFFF};
      if (r < -65'sd2147483648) return {1'b1, 32'h8000_0000};
      return {1'b0, r[31:0]};
    end
  endfunction

  logic [32:0] sx, sy;
  assign sx = sat_add(px_r, dx_r);
  assign sy = sat_add(py_r, dy_r);
  logic signed [67:0] rnd_sum;
  assign rnd_sum = acc_r + mp + 68'sd536870912;

  // datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; ovalid_r <= 1'b0; ph_r <= '0;
      px_r <= '0; py_r <= '0; hd_r <= '0; sat_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_nxt != st_r) ph_r <= '0;
      else ph_r <= ph_r + 3'd1;
      if (accept) begin
        cmd_r <= in_tuser;
        vx_in_r <= in_tdata[23:0]; vy_in_r <= in_tdata[47:24];
        w_r <= in_tdata[71:48]; dt_r <= in_tdata[88:73];
        lx_r <= in_tdata[120:89]; ly_r <= in_tdata[152:121];
        lh_r <= in_tdata[168:153];
        vx_r <= 34'($signed(in_tdata[23:0]));
        vy_r <= 34'($signed(in_tdata[47:24]));
      end
      unique case (st_r)
        ST_ROT_M: begin
          // product lands in the cycle after its operands
          unique case (ph_r)
            3'd1: acc_r <= mp;
            3'd2: vx_r <= 34'((acc_r - mp + 68'sd536870912) >>> 30);
            3'd3: acc_r <= mp;
            3'd4: vy_r <= 34'(rnd_sum >>> 30);
            default: ;
          endcase
        end
        ST_ANGLE: begin
          // angle modulo 2^32: high word of the low product plus low word
          // of the high product
          unique case (ph_r)
            3'd1: acc_r <= mp;
            3'd3: a32_r <= 32'((mp + 68'sh8000_0000) >>> 32);
            3'd4: a32_r <= a32_r + mp[31:0];
            default: ;
          endcase
        end
        ST_ARC_M: begin
          unique case (ph_r)
            3'd1: acc_r <= mp;
            3'd2: nx_r <= 64'(acc_r + mp);
            3'd3: acc_r <= mp;
            3'd4: ny_r <= 64'(acc_r - mp);
            default: ;
          endcase
        end
        ST_DIV: begin
          if (dst.done && !div2_r) dx_r <= dquo;
          if (dst.done && div2_r) dy_r <= dquo;
        end
        ST_LINE: begin
          unique case (ph_r)
            3'd1: dx_r <= 64'((mp + 68'sd32768) >>> 16);
            3'd2: dy_r <= 64'((mp + 68'sd32768) >>> 16);
            default: ;
          endcase
        end
        ST_UPDATE: begin
          if (cmd_r) begin
            px_r <= lx_r; py_r <= ly_r; hd_r <= lh_r; sat_r <= 1'b0;
          end else begin
            px_r <= sx[31:0]; py_r <= sy[31:0]; sat_r <= sx[32] | sy[32];
            if (!straight) hd_r <= hd_r + 16'((a32_r + 32'h8000) >> 16);
          end
          ovalid_r <= 1'b1;
        end
        ST_OUT: if (out_tready) ovalid_r <= 1'b0;
        default: ;
      endcase
    end
  end

  // second quotient: divider restarts for dy after dx returns
  always_ff @(posedge clk) begin
    if (!rst_n) div2_r <= 1'b0;
    else if (st_r == ST_DIV && dst.done && !div2_r) div2_r <= 1'b1;
    else if (st_r != ST_DIV) div2_r <= 1'b0;
  end

  `PEAI_ASSERT_IMP(a_no_ready_busy, clk, rst_n, st_r != ST_IDLE, !in_tready)
  `PEAI_ASSERT_IMP(a_valid_out, clk, rst_n, out_tvalid, st_r == ST_OUT)
  `PEAI_ASSERT_NXT(a_load_sat0, clk, rst_n, st_r == ST_UPDATE && cmd_r, !sat_r)
endmodule
